@@ rtl/core/ilt_pkg.sv @@
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared sizes, operation codes and status codes of the indexed list table.
// ----------------------------------------------------------------------------
package ilt_pkg;

    // Number of slots in the table.
    localparam int CAPACITY = 1024;
    // Bits of a slot number.
    localparam int SLOT_W   = $clog2(CAPACITY);
    // Bits of a list length; it must be able to hold CAPACITY itself.
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Widths fixed by the item fields.
    localparam int OP_W     = 3;
    localparam int POS_W    = 11;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_AT     = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ rtl/core/ilt_ram.sv @@
// ----------------------------------------------------------------------------
// ilt_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ilt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write if enabled; read data is registered and gives the old contents on a write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/core/indexed_list_table.sv @@
// ----------------------------------------------------------------------------
// indexed_list_table
// Ordered list of signed 32-bit values held in slot memories with next links
// and a free-slot stack.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its result has been issued, and the result appears for one cycle with done
// high. The receiver cannot stall, so the result must be captured on that
// cycle. Reaching list position p walks the link chain through the single
// port of the link memory, each step passing through S_WALK and S_WALK_W, so
// reads, inserts and deletes take longer the further down the list they reach.
// Insert at the head, delete at the head, out-of-range and refused requests
// need no walk. The free-slot stack needs no clearing pass after reset:
// entries at or above the highest list length yet reached read as their own
// index.
module indexed_list_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ilt_pkg::OP_W-1:0]      operation,
    input  logic [ilt_pkg::POS_W-1:0]     position,
    input  logic signed [ilt_pkg::VAL_W-1:0] item_value,
    output logic                          busy,
    output logic                          done,
    output logic signed [ilt_pkg::VAL_W-1:0] read_value,
    output logic                          found,
    output logic [ilt_pkg::ST_W-1:0]      status
);

    import ilt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE_W,
        S_WALK,
        S_WALK_W,
        S_RD_W,
        S_INS_W1,
        S_INS_W2,
        S_DEL0_W,
        S_DEL_W1,
        S_DEL_W2
    } state_t;

    state_t              state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [SLOT_W-1:0]   steps_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [SLOT_W-1:0]   fresh_reg;
    logic [SLOT_W-1:0]   victim_reg;
    logic [SLOT_W-1:0]   first_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    high_reg;
    logic                done_reg;
    logic                found_reg;
    logic [VAL_W-1:0]    rval_reg;
    logic [ST_W-1:0]     status_reg;

    // Memory ports.
    logic [SLOT_W-1:0]   val_addr;
    logic                val_we;
    logic [VAL_W-1:0]    val_rd;
    logic [SLOT_W-1:0]   lnk_addr;
    logic                lnk_we;
    logic [SLOT_W-1:0]   lnk_wd;
    logic [SLOT_W-1:0]   lnk_rd;
    logic [SLOT_W-1:0]   free_addr;
    logic                free_we;
    logic [SLOT_W-1:0]   free_wd;
    logic [SLOT_W-1:0]   free_rd;

    logic [CNT_W-1:0]    ins_pos;
    logic [CNT_W-1:0]    count_dec;
    logic [SLOT_W-1:0]   fresh_slot;

    // The insert goes to the head when the latched position is zero.
    function automatic logic ins_pos_zero(
        input logic [OP_W-1:0]   op,
        input logic [SLOT_W-1:0] steps,
        input logic [CNT_W-1:0]  cnt
    );
        logic zero;
        zero = 1'b0;
        case (op)
            OP_HEAD: zero = 1'b1;
            OP_TAIL: zero = (cnt == '0);
            default: zero = (steps == '0);
        endcase
        return zero;
    endfunction

    // Insert position for the three insert operations.
    always_comb
    begin
        case (operation)
            OP_HEAD: ins_pos = '0;
            OP_TAIL: ins_pos = count_reg;
            default: ins_pos = CNT_W'(position);
        endcase
    end

    assign count_dec = count_reg - CNT_W'(1);

    // Stack entries never written yet count as their own index.
    assign fresh_slot = (count_reg == high_reg) ? count_reg[SLOT_W-1:0] : free_rd;

    // Memory access for each sequencer state.
    always_comb
    begin
        val_addr  = cur_reg;
        val_we    = 1'b0;
        lnk_addr  = cur_reg;
        lnk_we    = 1'b0;
        lnk_wd    = lnk_rd;
        free_addr = count_reg[SLOT_W-1:0];
        free_we   = 1'b0;
        free_wd   = victim_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                lnk_addr = first_reg;
            end
            S_FREE_W:
            begin
                val_addr = fresh_slot;
                lnk_addr = fresh_slot;
                lnk_wd   = first_reg;
                if (ins_pos_zero(op_reg, steps_reg, count_reg))
                begin
                    val_we = 1'b1;
                    lnk_we = 1'b1;
                end
            end
            S_WALK, S_WALK_W, S_RD_W:
            begin
                lnk_addr = cur_reg;
            end
            S_INS_W1:
            begin
                val_addr = fresh_reg;
                val_we   = 1'b1;
                lnk_addr = fresh_reg;
                lnk_wd   = lnk_rd;
                lnk_we   = 1'b1;
            end
            S_INS_W2:
            begin
                lnk_addr = cur_reg;
                lnk_wd   = fresh_reg;
                lnk_we   = 1'b1;
            end
            S_DEL0_W:
            begin
                free_addr = count_dec[SLOT_W-1:0];
                free_wd   = first_reg;
                free_we   = 1'b1;
            end
            S_DEL_W1:
            begin
                lnk_addr = lnk_rd;
            end
            S_DEL_W2:
            begin
                lnk_addr  = cur_reg;
                lnk_wd    = lnk_rd;
                lnk_we    = 1'b1;
                free_addr = count_dec[SLOT_W-1:0];
                free_wd   = victim_reg;
                free_we   = 1'b1;
            end
            default:
            begin
                lnk_addr = cur_reg;
            end
        endcase
    end

    // Sequencer with registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            first_reg  <= '0;
            count_reg  <= '0;
            high_reg   <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            rval_reg   <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= operation;
                        val_reg    <= item_value;
                        cur_reg    <= first_reg;
                        found_reg  <= 1'b0;
                        rval_reg   <= '0;
                        status_reg <= ST_DONE;
                        case (operation)
                            OP_READ:
                            begin
                                if (CNT_W'(position) >= count_reg)
                                begin
                                    status_reg <= ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    steps_reg <= position[SLOT_W-1:0];
                                    state_reg <= S_WALK;
                                end
                            end
                            OP_HEAD, OP_TAIL, OP_AT:
                            begin
                                if (ins_pos > count_reg)
                                begin
                                    status_reg <= ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else if (count_reg == CNT_W'(CAPACITY))
                                begin
                                    status_reg <= ST_FULL;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    // Holds the position; zero means head.
                                    steps_reg <= ins_pos[SLOT_W-1:0];
                                    state_reg <= S_FREE_W;
                                end
                            end
                            OP_DELETE:
                            begin
                                if (CNT_W'(position) >= count_reg)
                                begin
                                    status_reg <= ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                                else if (position == '0)
                                begin
                                    state_reg <= S_DEL0_W;
                                end
                                else
                                begin
                                    steps_reg <= position[SLOT_W-1:0] - SLOT_W'(1);
                                    state_reg <= S_WALK;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FREE_W:
                begin
                    fresh_reg <= fresh_slot;
                    if (count_reg == high_reg)
                    begin
                        high_reg <= high_reg + CNT_W'(1);
                    end
                    if (ins_pos_zero(op_reg, steps_reg, count_reg))
                    begin
                        first_reg <= fresh_slot;
                        count_reg <= count_reg + CNT_W'(1);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        // Walk to the predecessor of the insert position.
                        steps_reg <= steps_reg - SLOT_W'(1);
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (steps_reg == '0)
                    begin
                        case (op_reg)
                            OP_READ:   state_reg <= S_RD_W;
                            OP_DELETE: state_reg <= S_DEL_W1;
                            default:   state_reg <= S_INS_W1;
                        endcase
                    end
                    else
                    begin
                        state_reg <= S_WALK_W;
                    end
                end
                S_WALK_W:
                begin
                    cur_reg   <= lnk_rd;
                    steps_reg <= steps_reg - SLOT_W'(1);
                    state_reg <= S_WALK;
                end
                S_RD_W:
                begin
                    rval_reg  <= val_rd;
                    found_reg <= 1'b1;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_INS_W1:
                begin
                    state_reg <= S_INS_W2;
                end
                S_INS_W2:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DEL0_W:
                begin
                    first_reg <= lnk_rd;
                    count_reg <= count_dec;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DEL_W1:
                begin
                    victim_reg <= lnk_rd;
                    state_reg  <= S_DEL_W2;
                end
                S_DEL_W2:
                begin
                    count_reg <= count_dec;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Slot values, slot links and the free-slot stack.
    ilt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
        .clk   (clk),
        .addr  (val_addr),
        .we    (val_we),
        .wdata (val_reg),
        .rdata (val_rd)
    );

    ilt_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
        .clk   (clk),
        .addr  (lnk_addr),
        .we    (lnk_we),
        .wdata (lnk_wd),
        .rdata (lnk_rd)
    );

    ilt_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
        .clk   (clk),
        .addr  (free_addr),
        .we    (free_we),
        .wdata (free_wd),
        .rdata (free_rd)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = rval_reg;
    assign status     = status_reg;

endmodule

@@ rtl/core/ilt_checker.sv @@
// ----------------------------------------------------------------------------
// ilt_checker
// Port-level checks of the indexed list table, bound to the top level.
// ----------------------------------------------------------------------------
module ilt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [ilt_pkg::VAL_W-1:0] read_value,
    input logic                          found,
    input logic [ilt_pkg::ST_W-1:0]      status
);

    import ilt_pkg::*;

    // A result only follows an accepted item or work in progress.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without an item");

    // An accepted item either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item dropped");

    // A successful read always reports done.
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_DONE))
        else $error("found with a failure status");

    // Results that are not successful reads carry a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (read_value == '0))
        else $error("value without a hit");

endmodule

bind indexed_list_table ilt_checker u_ilt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .found      (found),
    .status     (status)
);
